FILE: rtl/frame_receive_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Frame receive parser assertion macros
// Shared property forms for the parser checker; they sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_RECEIVE_PARSER_CORE_ASSERT_SVH
`define FRAME_RECEIVE_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define FRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// Frame receive parser package
// Codes, result beat type and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0]  START_BYTE = 8'h01;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [2:0]  LEN_BYTES  = 3'd2;
  localparam logic [2:0]  SUM_BYTES  = 3'd4;

  // parse phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_XOR  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;

  // frame status
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_GOOD     = 3'd1;
  localparam logic [2:0] ST_SUM_BAD  = 3'd2;
  localparam logic [2:0] ST_XOR_BAD  = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_TYPE   = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] MAX_LENGTH_RST = 16'd256;
  localparam logic [7:0]  NONE_TYPE_RST  = 8'd0;
  localparam logic [7:0]  CRC_TYPE_RST   = 8'd32;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic [2:0]  frame_status;
    logic [15:0] frame_length;
    logic [7:0]  frame_type;
  } frp_res_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/frame_receive_parser_core.sv
// ----------------------------------------------------------------------------
// Frame receive parser core
// Parses start byte, type, length, header XOR, payload and CRC-32 trailer,
// one received byte per beat, one result beat per input beat.
// ----------------------------------------------------------------------------
// A result beat is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle while in_stall is low; the byte-wide CRC-32 update
//   and the phase logic are combinational between the parser state and the result register.
// A two-entry output buffer lets one more input beat in while a result is stalled.
// Reset (rst_n low, synchronous) idles the parser and restores register defaults.
module frame_receive_parser_core
  import frp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_data_valid,
  output logic [7:0]            out_data_byte,
  output logic [15:0]           out_data_index,
  output logic [2:0]            out_frame_status,
  output logic [15:0]           out_frame_length,
  output logic [7:0]            out_frame_type
);

  logic [15:0] max_len_r;
  logic [7:0]  none_code_r, crc_code_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  hxor_r, hxor_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [31:0] mbv_r, mbv_nxt;
  logic [2:0]  mbc_r, mbc_nxt;
  logic [31:0] crc_r, crc_nxt;

  frp_res_t res;
  frp_res_t out_r, skid_r;
  logic     out_valid_r, skid_valid_r;
  logic     in_acc, main_free, finish;
  logic [15:0] cnt_inc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign cnt_inc  = cnt_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LENGTH_RST;
      none_code_r <= NONE_TYPE_RST;
      crc_code_r  <= CRC_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH: max_len_r   <= cfg_wdata;
        CFG_NONE_TYPE:  none_code_r <= cfg_wdata[7:0];
        CFG_CRC_TYPE:   crc_code_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hxor_nxt  = hxor_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    mbv_nxt   = mbv_r;
    mbc_nxt   = mbc_r;
    crc_nxt   = crc_r;
    finish    = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_TYPE: begin
        type_nxt  = in_rx_byte;
        hxor_nxt  = hxor_r ^ in_rx_byte;
        mbv_nxt   = '0;
        mbc_nxt   = '0;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        mbv_nxt  = mbv_r | ({24'h0, in_rx_byte} << (mbc_r[0] ? 5'd8 : 5'd0));
        mbc_nxt  = mbc_r + 3'd1;
        hxor_nxt = hxor_r ^ in_rx_byte;
        if (mbc_nxt >= LEN_BYTES) begin
          len_nxt = mbv_nxt[15:0];
          if (mbv_nxt[15:0] == 16'd0) begin
            res.frame_status = ST_ZERO_LEN;
            finish           = 1'b1;
          end else begin
            phase_nxt = PH_XOR;
          end
        end
      end
      PH_XOR: begin
        if (hxor_r != in_rx_byte) begin
          res.frame_status = ST_XOR_BAD;
          finish           = 1'b1;
        end else if (len_r > max_len_r) begin
          res.frame_status = ST_TOO_LONG;
          finish           = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
          cnt_nxt   = '0;
          crc_nxt   = CRC_INIT;
        end
      end
      PH_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = in_rx_byte;
        res.data_index = cnt_r;
        cnt_nxt        = cnt_inc;
        if (type_r == crc_code_r) crc_nxt = crc32_byte(crc_r, in_rx_byte);
        if (cnt_inc >= len_r) begin
          if (type_r != none_code_r) begin
            phase_nxt = PH_SUM;
            mbv_nxt   = '0;
            mbc_nxt   = '0;
          end else begin
            res.frame_status = ST_GOOD;
            finish           = 1'b1;
          end
        end
      end
      PH_SUM: begin
        mbv_nxt = mbv_r | ({24'h0, in_rx_byte} << {mbc_r[1:0], 3'b000});
        mbc_nxt = mbc_r + 3'd1;
        if (mbc_nxt >= SUM_BYTES) begin
          if (type_r == crc_code_r && ~crc_r != mbv_nxt) res.frame_status = ST_SUM_BAD;
          else res.frame_status = ST_GOOD;
          finish = 1'b1;
        end
      end
      default: begin
        if (in_rx_byte == START_BYTE) begin
          type_nxt  = none_code_r;
          len_nxt   = '0;
          cnt_nxt   = '0;
          mbv_nxt   = '0;
          mbc_nxt   = '0;
          crc_nxt   = CRC_INIT;
          hxor_nxt  = START_BYTE;
          phase_nxt = PH_TYPE;
        end
      end
    endcase
    res.frame_length = len_nxt;
    res.frame_type   = type_nxt;
    if (finish) begin
      phase_nxt = PH_IDLE;
      hxor_nxt  = '0;
      type_nxt  = none_code_r;
      len_nxt   = '0;
      cnt_nxt   = '0;
      mbv_nxt   = '0;
      mbc_nxt   = '0;
      crc_nxt   = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hxor_r  <= '0;
      type_r  <= NONE_TYPE_RST;
      len_r   <= '0;
      cnt_r   <= '0;
      mbv_r   <= '0;
      mbc_r   <= '0;
      crc_r   <= CRC_INIT;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      hxor_r  <= hxor_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      mbv_r   <= mbv_nxt;
      mbc_r   <= mbc_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // output register plus skid entry
  assign main_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_acc) out_r <= res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = out_r.data_valid;
  assign out_data_byte    = out_r.data_byte;
  assign out_data_index   = out_r.data_index;
  assign out_frame_status = out_r.frame_status;
  assign out_frame_length = out_r.frame_length;
  assign out_frame_type   = out_r.frame_type;

endmodule

FILE: rtl/frame_receive_parser_core_chk.sv
// ----------------------------------------------------------------------------
// Frame receive parser checker
// Port-level checks on result beats, bound to the parser core.
// ----------------------------------------------------------------------------
`include "frame_receive_parser_core_assert.svh"

module frame_receive_parser_core_chk
  import frp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_data_valid,
  input logic [7:0]            out_data_byte,
  input logic [15:0]           out_data_index,
  input logic [2:0]            out_frame_status
);

  `FRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data_byte) && $stable(out_frame_status) && $stable(out_data_index), "stalled result beat changed")

  `FRP_ASSERT_NOW(a_no_data_zero, out_valid && !out_data_valid, out_data_byte == 8'd0 && out_data_index == 16'd0, "non-payload beat carries data")

  `FRP_ASSERT_NOW(a_abort_no_data, out_valid && (out_frame_status == ST_XOR_BAD || out_frame_status == ST_ZERO_LEN || out_frame_status == ST_TOO_LONG), !out_data_valid, "header abort on a payload beat")

  `FRP_ASSERT_NOW(a_status_range, out_valid, out_frame_status <= ST_TOO_LONG, "undefined frame status")

endmodule

bind frame_receive_parser_core frame_receive_parser_core_chk u_chk (.*);
